/* design/lph_pkg.sv */
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types and constants for the linear-probe get-or-insert hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package lph_pkg;

    // Default table size, log2 of the slot count
    localparam int LOG_SLOTS = 10;

    localparam int KEY_W   = 64;
    localparam int VALUE_W = 31;

    // All-ones key marks an empty slot
    localparam logic [KEY_W-1:0] EMPTY_KEY = '1;

    // Mixer multiplier constants (64-bit finalizer)
    localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

    // Mixer xor-shift amounts
    localparam int MIX_SH0 = 30;
    localparam int MIX_SH1 = 27;
    localparam int MIX_SH2 = 31;

    // Result status codes
    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_INSERTED = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    // Input item
    typedef struct packed {
        logic [KEY_W-1:0]   lookup_key;
        logic [VALUE_W-1:0] new_value;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [VALUE_W-1:0] found_value;
        logic [1:0]         status;
    } t_out_item;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic    clr_write;   // write empty marker at clear pointer
        logic    load_req;    // capture incoming item
        logic    mix_start;   // start the key mixer
        logic    load_idx;    // take home slot from mixer, read it
        logic    advance;     // step to next slot, read it
        logic    ins_write;   // write key and value at current slot
        logic    res_load;    // capture pending result
        t_status res_code;    // which result to capture
        logic    out_load;    // move pending result to output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;       // clear pointer at last slot
        logic key_reserved;   // incoming key is the empty marker
        logic mix_done;       // mixer result ready
        logic hit;            // probed slot holds the key
        logic empty;          // probed slot is empty
        logic last_probe;     // every slot probed after this one
    } t_stat;

endpackage

`default_nettype wire

/* design/lph_ram.sv */
// ----------------------------------------------------------------------------
// lph_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lph_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* design/lph_mix.sv */
// ----------------------------------------------------------------------------
// lph_mix
// Iterative 64-bit key mixer: xor-shift, multiply, xor-shift, multiply,
// xor-shift. Each 64x64 low-half product is built from three 32x32 partial
// products, one per cycle, on a single shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module lph_mix (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_key,
    output logic             o_done,
    output logic      [63:0] o_hash
);

    localparam logic [2:0] PH_LAST = 3'd5;
    localparam logic [2:0] PH_MID  = 3'd2;

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [2:0]  r_phase, n_phase;
    logic [63:0] r_x, n_x;
    logic [63:0] r_acc, n_acc;

    logic [63:0] mul_c;
    logic [31:0] op_a, op_b;
    logic [63:0] prod;
    logic [31:0] hi_sum;
    logic [63:0] full;
    logic [63:0] shifted;

    // Partial product operand select
    always_comb begin
        mul_c = (r_phase > PH_MID) ? lph_pkg::MIX_C2 : lph_pkg::MIX_C1;
        op_a  = r_x[31:0];
        op_b  = mul_c[31:0];
        unique case (r_phase)
            3'd0, 3'd3: begin
                op_a = r_x[31:0];
                op_b = mul_c[31:0];
            end
            3'd1, 3'd4: begin
                op_a = r_x[31:0];
                op_b = mul_c[63:32];
            end
            default: begin
                op_a = r_x[63:32];
                op_b = mul_c[31:0];
            end
        endcase
    end

    // Shared multiplier, upper-half accumulate, closing xor-shift
    always_comb begin
        prod    = {32'd0, op_a} * {32'd0, op_b};
        hi_sum  = r_acc[63:32] + prod[31:0];
        full    = {hi_sum, r_acc[31:0]};
        shifted = (r_phase == PH_MID) ? (full >> lph_pkg::MIX_SH1)
                                      : (full >> lph_pkg::MIX_SH2);
    end

    // Next-state logic
    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_phase = r_phase;
        n_x     = r_x;
        n_acc   = r_acc;
        if (i_start) begin
            n_busy  = 1'b1;
            n_phase = 3'd0;
            n_x     = i_key ^ (i_key >> lph_pkg::MIX_SH0);
        end else if (r_busy) begin
            n_phase = r_phase + 3'd1;
            unique case (r_phase)
                3'd0, 3'd3: begin
                    n_acc = prod;
                end
                3'd1, 3'd4: begin
                    n_acc = {hi_sum, r_acc[31:0]};
                end
                default: begin
                    n_x = full ^ shifted;
                    if (r_phase == PH_LAST) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 3'd0;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_phase <= n_phase;
        end
    end

    // Data registers
    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_acc <= n_acc;
    end

    assign o_done = r_done;
    assign o_hash = r_x;

endmodule

`default_nettype wire

/* design/lph_dp.sv */
// ----------------------------------------------------------------------------
// lph_dp
// Datapath: item capture, key mixer, slot index and probe counter, key and
// value memories, match compare, pending result and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lph_dp #(
    parameter int LOG_SLOTS = lph_pkg::LOG_SLOTS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire lph_pkg::t_cmd       i_cmd,
    output lph_pkg::t_stat           o_stat,
    input  wire lph_pkg::t_in_item   i_in_item,
    output lph_pkg::t_out_item       o_out_item
);

    localparam int SLOTS = 1 << LOG_SLOTS;

    logic [lph_pkg::KEY_W-1:0]   r_key;
    logic [lph_pkg::VALUE_W-1:0] r_value;
    logic [LOG_SLOTS-1:0]        r_idx;
    logic [LOG_SLOTS-1:0]        r_probes;
    logic [LOG_SLOTS-1:0]        r_clr;
    lph_pkg::t_out_item          r_res;
    lph_pkg::t_out_item          r_out;

    logic                        mix_done;
    logic [63:0]                 mix_hash;
    logic [LOG_SLOTS-1:0]        rd_addr;
    logic [lph_pkg::KEY_W-1:0]   rd_key;
    logic [lph_pkg::VALUE_W-1:0] rd_value;
    logic                        key_we;
    logic [LOG_SLOTS-1:0]        key_waddr;
    logic [lph_pkg::KEY_W-1:0]   key_wdata;
    lph_pkg::t_out_item          res_next;

    // Key mixer
    lph_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mix_start),
        .i_key   (i_in_item.lookup_key),
        .o_done  (mix_done),
        .o_hash  (mix_hash)
    );

    // Read address: home slot on load, next slot otherwise
    assign rd_addr = i_cmd.load_idx ? mix_hash[LOG_SLOTS-1:0] : r_idx + 1'b1;

    // Key store write: clearing pass or insert
    assign key_we    = i_cmd.clr_write | i_cmd.ins_write;
    assign key_waddr = i_cmd.clr_write ? r_clr : r_idx;
    assign key_wdata = i_cmd.clr_write ? lph_pkg::EMPTY_KEY : r_key;

    lph_ram #(
        .WIDTH (lph_pkg::KEY_W),
        .DEPTH (SLOTS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_key)
    );

    lph_ram #(
        .WIDTH (lph_pkg::VALUE_W),
        .DEPTH (SLOTS)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ins_write),
        .i_waddr (r_idx),
        .i_wdata (r_value),
        .i_raddr (rd_addr),
        .o_rdata (rd_value)
    );

    // Status to controller
    always_comb begin
        o_stat.clr_last     = &r_clr;
        o_stat.key_reserved = (i_in_item.lookup_key == lph_pkg::EMPTY_KEY);
        o_stat.mix_done     = mix_done;
        o_stat.hit          = (rd_key == r_key);
        o_stat.empty        = (rd_key == lph_pkg::EMPTY_KEY);
        o_stat.last_probe   = &r_probes;
    end

    // Pending result select
    always_comb begin
        res_next.status = i_cmd.res_code;
        unique case (i_cmd.res_code)
            lph_pkg::ST_FOUND:    res_next.found_value = rd_value;
            lph_pkg::ST_INSERTED: res_next.found_value = r_value;
            default:              res_next.found_value = '0;
        endcase
    end

    // Clear pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_write) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // Item capture, probe position, results
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_key   <= i_in_item.lookup_key;
            r_value <= i_in_item.new_value;
        end
        if (i_cmd.load_idx) begin
            r_idx    <= mix_hash[LOG_SLOTS-1:0];
            r_probes <= '0;
        end else if (i_cmd.advance) begin
            r_idx    <= r_idx + 1'b1;
            r_probes <= r_probes + 1'b1;
        end
        if (i_cmd.res_load) begin
            r_res <= res_next;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_item = r_out;

endmodule

`default_nettype wire

/* design/lph_ctrl.sv */
// ----------------------------------------------------------------------------
// lph_ctrl
// Controller: clearing pass after reset, item accept, wait on mixer, probe
// loop, result handoff into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lph_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output lph_pkg::t_cmd       o_cmd,
    input  wire lph_pkg::t_stat i_stat
);

    lph_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            accept;
    logic            out_free;

    assign accept   = (r_state == lph_pkg::S_IDLE) && i_in_valid;
    assign out_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lph_pkg::S_CLEAR: begin
                if (i_stat.clr_last) n_state = lph_pkg::S_IDLE;
            end
            lph_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = i_stat.key_reserved ? lph_pkg::S_DONE : lph_pkg::S_HASH;
                end
            end
            lph_pkg::S_HASH: begin
                if (i_stat.mix_done) n_state = lph_pkg::S_PROBE;
            end
            lph_pkg::S_PROBE: begin
                if (i_stat.hit || i_stat.empty || i_stat.last_probe) begin
                    n_state = lph_pkg::S_DONE;
                end
            end
            lph_pkg::S_DONE: begin
                if (out_free) n_state = lph_pkg::S_IDLE;
            end
            default: n_state = lph_pkg::S_CLEAR;
        endcase
    end

    // Outputs and datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.res_code = lph_pkg::ST_FULL;
        o_in_ready     = 1'b0;
        unique case (r_state)
            lph_pkg::S_CLEAR: begin
                o_cmd.clr_write = 1'b1;
            end
            lph_pkg::S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_req  = accept;
                o_cmd.mix_start = accept && !i_stat.key_reserved;
                o_cmd.res_load  = accept && i_stat.key_reserved;
                o_cmd.res_code  = lph_pkg::ST_FULL;
            end
            lph_pkg::S_HASH: begin
                o_cmd.load_idx = i_stat.mix_done;
            end
            lph_pkg::S_PROBE: begin
                priority if (i_stat.hit) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_code = lph_pkg::ST_FOUND;
                end else if (i_stat.empty) begin
                    o_cmd.ins_write = 1'b1;
                    o_cmd.res_load  = 1'b1;
                    o_cmd.res_code  = lph_pkg::ST_INSERTED;
                end else if (i_stat.last_probe) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_code = lph_pkg::ST_FULL;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            lph_pkg::S_DONE: begin
                o_cmd.out_load = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // Output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lph_pkg::S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* design/linear_probe_hash_get_or_insert_top.sv */
// ----------------------------------------------------------------------------
// linear_probe_hash_get_or_insert_top
// Get-or-insert hash table with open addressing and linear probing.
//
//   channel  | valid        | ready        | payload
//   ---------+--------------+--------------+----------------------------------
//   request  | i_in_valid   | o_in_ready   | i_in_item  (lookup_key, new_value)
//   result   | o_out_valid  | i_out_ready  | o_out_item (found_value, status)
//
// One item at a time: accept, key mixing (six steps on one shared 32x32
// multiplier, then a registered done flag), one probed slot after another
// (key and value memory reads), then the handoff to the output register.
// After reset a clearing pass writes the empty marker to all 2^LOG_SLOTS
// key slots, one per cycle; o_in_ready stays low until the pass ends.
// A waiting result does not block the next item until that item's own result
// is ready to be handed over.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_get_or_insert_top #(
    parameter int LOG_SLOTS = lph_pkg::LOG_SLOTS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire lph_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output lph_pkg::t_out_item      o_out_item
);

    lph_pkg::t_cmd  cmd;
    lph_pkg::t_stat stat;

    lph_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    lph_dp #(
        .LOG_SLOTS (LOG_SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_in_item  (i_in_item),
        .o_out_item (o_out_item)
    );

endmodule

`default_nettype wire
